// ===== hw/rtl/rast_pkg.sv =====
// shared types and constants for the integer line rasterizer
package rast_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 32;
   localparam int STEP_BITS  = COORD_BITS + 1;
   localparam int ACC_BITS   = COORD_BITS + 3;
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = $clog2(QDEPTH);
   localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic [STEP_BITS-1:0]       step_type;
   typedef logic signed [ACC_BITS-1:0] acc_type;
   typedef logic [QPTR_BITS-1:0]       qptr_type;
   typedef logic [QCNT_BITS-1:0]       qcnt_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // one classified command as it travels from front to back
   typedef struct packed {
      kind_type  kind;
      coord_type major_pos;
      coord_type minor_pos;
      coord_type major_end;
      coord_type major_span;
      step_type  error_step;
      acc_type   error_back;
      logic      minor_down;
      logic      steep;
      logic      active;
      color_type color;
   } cmd_type;

endpackage

// ===== hw/rtl/rast_if.sv =====
// valid/ready channel interfaces for commands and pixels
interface rast_req_if;
   import rast_pkg::*;

   logic      valid;
   logic      ready;
   logic      kind;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type draw_color;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, draw_color,
                   input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y, draw_color,
                   output ready);
endinterface

interface rast_rsp_if;
   import rast_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   color_type pixel_color;
   logic      last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== hw/rtl/rast_front.sv =====
// command classifier and line setup ahead of the queue
module rast_front (
   rast_req_if.sink     req_chan,
   input  logic         queue_full,
   output logic         push,
   output rast_pkg::cmd_type push_cmd
);
   import rast_pkg::*;

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic signed [COORD_BITS:0] dx_neg_val;
   logic signed [COORD_BITS:0] dy_neg_val;
   coord_type dx_abs;
   coord_type dy_abs;
   logic      steep;
   logic      major_neg;
   logic      minor_neg;
   coord_type major_a;
   coord_type major_b;
   coord_type minor_a;
   coord_type minor_b;
   coord_type span;
   coord_type minor_abs;
   step_type  err_step;

   // handshake: accept whenever the queue has room
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // signed deltas and their magnitudes
   assign dx         = $signed({1'b0, req_chan.end_x}) - $signed({1'b0, req_chan.start_x});
   assign dy         = $signed({1'b0, req_chan.end_y}) - $signed({1'b0, req_chan.start_y});
   assign dx_neg_val = -dx;
   assign dy_neg_val = -dy;
   assign dx_abs     = dx[COORD_BITS] ? coord_type'(dx_neg_val) : coord_type'(dx);
   assign dy_abs     = dy[COORD_BITS] ? coord_type'(dy_neg_val) : coord_type'(dy);

   // steep lines swap axes, equal spans stay shallow
   assign steep     = dx_abs < dy_abs;
   assign major_neg = steep ? dy[COORD_BITS] : dx[COORD_BITS];
   assign minor_neg = steep ? dx[COORD_BITS] : dy[COORD_BITS];
   assign major_a   = steep ? req_chan.start_y : req_chan.start_x;
   assign major_b   = steep ? req_chan.end_y   : req_chan.end_x;
   assign minor_a   = steep ? req_chan.start_x : req_chan.start_y;
   assign minor_b   = steep ? req_chan.end_x   : req_chan.end_y;
   assign span      = steep ? dy_abs : dx_abs;
   assign minor_abs = steep ? dx_abs : dy_abs;
   assign err_step  = {minor_abs, 1'b0};

   // order endpoints so the major coordinate counts upward
   always_comb begin
      push_cmd.kind       = kind_type'(req_chan.kind);
      push_cmd.major_pos  = major_neg ? major_b : major_a;
      push_cmd.minor_pos  = major_neg ? minor_b : minor_a;
      push_cmd.major_end  = major_neg ? major_a : major_b;
      push_cmd.major_span = span;
      push_cmd.error_step = err_step;
      push_cmd.error_back = acc_type'(err_step) - acc_type'({span, 1'b0});
      push_cmd.minor_down = (minor_abs == '0) || (minor_neg != major_neg);
      push_cmd.steep      = steep;
      push_cmd.active     = span != '0;
      push_cmd.color      = req_chan.draw_color;
   end

endmodule

// ===== hw/rtl/rast_queue.sv =====
// short command queue between setup and pixel stepping
module rast_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rast_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output rast_pkg::cmd_type head_cmd
);
   import rast_pkg::*;

   cmd_type  entry_ff [QDEPTH];
   qptr_type wr_ptr_ff;
   qptr_type wr_ptr_in;
   qptr_type rd_ptr_ff;
   qptr_type rd_ptr_in;
   qcnt_type count_ff;
   qcnt_type count_in;
   logic     do_pop;

   assign full       = count_ff == qcnt_type'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == qptr_type'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == qptr_type'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/rast_back.sv =====
// line state, error stepping and pixel output register
module rast_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  rast_pkg::cmd_type head_cmd,
   output logic              pop,
   rast_rsp_if.source        rsp_chan
);
   import rast_pkg::*;

   coord_type major_pos_ff;
   coord_type major_pos_in;
   coord_type minor_pos_ff;
   coord_type minor_pos_in;
   coord_type major_end_ff;
   coord_type major_end_in;
   coord_type major_span_ff;
   coord_type major_span_in;
   step_type  error_step_ff;
   step_type  error_step_in;
   acc_type   error_back_ff;
   acc_type   error_back_in;
   acc_type   error_acc_ff;
   acc_type   error_acc_in;
   logic      minor_down_ff;
   logic      minor_down_in;
   logic      steep_ff;
   logic      steep_in;
   logic      active_ff;
   logic      active_in;
   color_type line_color_ff;
   color_type line_color_in;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   coord_type rsp_x_ff;
   coord_type rsp_x_in;
   coord_type rsp_y_ff;
   coord_type rsp_y_in;
   color_type rsp_color_ff;
   color_type rsp_color_in;
   logic      rsp_last_ff;
   logic      rsp_last_in;

   logic      is_start;
   logic      out_free;
   logic      emit;
   coord_type major_next;
   logic      last_pixel;
   acc_type   acc_sum;
   acc_type   acc_back;
   logic      minor_step;

   // dispatch: starts always retire, steps on a live line wait for output room
   assign is_start = head_cmd.kind == KIND_START;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = head_valid && !is_start && active_ff && out_free;
   assign pop      = head_valid && (is_start || !active_ff || out_free);

   // error term: both candidate sums in parallel, one compare picks
   assign major_next = major_pos_ff + 1'b1;
   assign last_pixel = major_next == major_end_ff;
   assign acc_sum    = error_acc_ff + acc_type'(error_step_ff);
   assign acc_back   = error_acc_ff + error_back_ff;
   assign minor_step = acc_sum > $signed(acc_type'(major_span_ff));

   // line state update
   always_comb begin
      major_pos_in  = major_pos_ff;
      minor_pos_in  = minor_pos_ff;
      major_end_in  = major_end_ff;
      major_span_in = major_span_ff;
      error_step_in = error_step_ff;
      error_back_in = error_back_ff;
      error_acc_in  = error_acc_ff;
      minor_down_in = minor_down_ff;
      steep_in      = steep_ff;
      active_in     = active_ff;
      line_color_in = line_color_ff;
      if (head_valid && is_start) begin
         major_pos_in  = head_cmd.major_pos;
         minor_pos_in  = head_cmd.minor_pos;
         major_end_in  = head_cmd.major_end;
         major_span_in = head_cmd.major_span;
         error_step_in = head_cmd.error_step;
         error_back_in = head_cmd.error_back;
         error_acc_in  = '0;
         minor_down_in = head_cmd.minor_down;
         steep_in      = head_cmd.steep;
         active_in     = head_cmd.active;
         line_color_in = head_cmd.color;
      end else if (emit) begin
         major_pos_in = major_next;
         active_in    = !last_pixel;
         if (minor_step) begin
            minor_pos_in = minor_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            error_acc_in = acc_back;
         end else begin
            error_acc_in = acc_sum;
         end
      end
   end

   // output register, refilled in the cycle it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_y_in     = steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_color_in = line_color_ff;
         rsp_last_in  = last_pixel;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff  <= major_pos_in;
      minor_pos_ff  <= minor_pos_in;
      major_end_ff  <= major_end_in;
      major_span_ff <= major_span_in;
      error_step_ff <= error_step_in;
      error_back_ff <= error_back_in;
      error_acc_ff  <= error_acc_in;
      minor_down_ff <= minor_down_in;
      steep_ff      <= steep_in;
      line_color_ff <= line_color_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef SYNTHESIS
   // the final pixel closes the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      emit && last_pixel |=> !active_ff)
      else $error("line still active after its last pixel");

   // an active line never runs past its end
   a_pos_below_end: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> major_pos_ff < major_end_ff)
      else $error("major position reached end while active");

   // error stays within the span
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> error_acc_ff <= $signed(acc_type'(major_span_ff)))
      else $error("error accumulator above span");

   // a start clears the error term
   a_start_clears_acc: assert property (@(posedge clock) disable iff (reset)
      head_valid && is_start |=> error_acc_ff == '0)
      else $error("error accumulator not cleared by start");

   // no pixel is emitted over an unread one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("pixel emitted into a full output register");
`endif

endmodule

// ===== hw/rtl/integer_line_rasterizer.sv =====
// top level of the integer line rasterizer
//
//  channel    dir  handshake      beat
//  req_chan   in   valid/ready    kind, start_x, start_y, end_x, end_y, draw_color
//  rsp_chan   out  valid/ready    pixel_x, pixel_y, pixel_color, last
//
// one command per cycle is taken; a step with an active line gives one pixel a cycle
// the setup for a start (swap, order, deltas) is done ahead of a two-beat queue,
// the back end retires one queued command per cycle
// reset clears the queue, the output register and the line-active flag
// a stalled pixel output holds the back end; the queue then fills and drops req ready
module integer_line_rasterizer (
   input logic        clock,
   input logic        reset,
   rast_req_if.sink   req_chan,
   rast_rsp_if.source rsp_chan
);
   import rast_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   // command classification and setup
   rast_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decoupling queue
   rast_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // pixel stepping
   rast_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the integer line rasterizer against a line predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rast_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int ITEM_TARGET = 1100;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 32;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   // one command beat waiting to be sent, or a mark to wait for every pixel
   typedef struct {
      logic      hold_mark;
      logic      kind;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      color_type colour;
   } cmd_beat_type;

   typedef struct {
      coord_type x;
      coord_type y;
      color_type colour;
      logic      last;
   } pixel_type;

   // line being traced by the predictor
   typedef struct {
      coord_type major_pos;
      coord_type minor_pos;
      coord_type major_end;
      coord_type major_span;
      int        error_step;
      int        error_acc;
      logic      minor_down;
      logic      steep;
      logic      active;
      color_type colour;
   } line_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rast_req_if req_chan ();
   rast_rsp_if rsp_chan ();

   integer_line_rasterizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cmd_beat_type   backlog[$];
   pixel_type      expected_pixels[$];
   line_state_type trace;
   int             fail_count  = 0;
   int             pixels_seen = 0;
   int             cycle_count = 0;

   // clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int abs_gap(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // apply one accepted command to the traced line and queue any pixel it gives
   task automatic raster_command(input logic kind, input coord_type sx, input coord_type sy,
                                 input coord_type ex, input coord_type ey,
                                 input color_type colour);
      int        ax, ay, bx, by, t;
      pixel_type pix;
      if (kind_type'(kind) == KIND_START) begin
         ax = sx;
         ay = sy;
         bx = ex;
         by = ey;
         trace.steep = abs_gap(bx, ax) < abs_gap(by, ay);
         if (trace.steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
         end
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
         trace.major_pos  = coord_type'(ax);
         trace.minor_pos  = coord_type'(ay);
         trace.major_end  = coord_type'(bx);
         trace.major_span = coord_type'(bx - ax);
         trace.error_step = 2 * abs_gap(by, ay);
         trace.error_acc  = 0;
         trace.minor_down = !(by > ay);
         trace.colour     = colour;
         trace.active     = (bx != ax);
      end else if (trace.active) begin
         // emit the current pixel, roles swapped back for a steep line
         pix.x      = trace.steep ? trace.minor_pos : trace.major_pos;
         pix.y      = trace.steep ? trace.major_pos : trace.minor_pos;
         pix.colour = trace.colour;
         pix.last   = (int'(trace.major_pos) + 1 == int'(trace.major_end));
         expected_pixels.push_back(pix);
         // error term: minor axis steps only when strictly above the span
         trace.error_acc += trace.error_step;
         if (trace.error_acc > int'(trace.major_span)) begin
            trace.minor_pos = trace.minor_down ? trace.minor_pos - 1'b1 : trace.minor_pos + 1'b1;
            trace.error_acc -= 2 * int'(trace.major_span);
         end
         trace.major_pos = trace.major_pos + 1'b1;
         if (trace.major_pos == trace.major_end)
            trace.active = 1'b0;
      end
   endtask

   task automatic push_start(input int sx, input int sy, input int ex, input int ey,
                             input color_type colour);
      cmd_beat_type b;
      b.hold_mark = 1'b0;
      b.kind      = KIND_START;
      b.start_x   = coord_type'(sx);
      b.start_y   = coord_type'(sy);
      b.end_x     = coord_type'(ex);
      b.end_y     = coord_type'(ey);
      b.colour    = colour;
      backlog.push_back(b);
   endtask

   // step beats carry random payload, which the block ignores
   task automatic push_steps(input int n);
      cmd_beat_type b;
      for (int i = 0; i < n; i++) begin
         b.hold_mark = 1'b0;
         b.kind      = KIND_STEP;
         b.start_x   = coord_type'($urandom);
         b.start_y   = coord_type'($urandom);
         b.end_x     = coord_type'($urandom);
         b.end_y     = coord_type'($urandom);
         b.colour    = $urandom;
         backlog.push_back(b);
      end
   endtask

   task automatic push_hold();
      cmd_beat_type b;
      b = '{default: '0};
      b.hold_mark = 1'b1;
      backlog.push_back(b);
   endtask

   // driver: bursts of beats with random gaps, pausing at hold marks until all pixels are in
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (backlog.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (backlog[0].hold_mark) begin
            req_chan.valid <= 1'b0;
            if (!req_chan.valid && expected_pixels.size() == 0)
               void'(backlog.pop_front());
         end else begin
            req_chan.valid      <= 1'b1;
            req_chan.kind       <= backlog[0].kind;
            req_chan.start_x    <= backlog[0].start_x;
            req_chan.start_y    <= backlog[0].start_y;
            req_chan.end_x      <= backlog[0].end_x;
            req_chan.end_y      <= backlog[0].end_y;
            req_chan.draw_color <= backlog[0].colour;
            void'(backlog.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // receiver: changing stall pattern, plus two long hold-offs to back the block up
   int hold_left  = 0;
   int holds_done = 0;
   int mode       = 0;
   int mode_left  = 0;
   int tick       = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if ((holds_done == 0 && pixels_seen >= 200) ||
                   (holds_done == 1 && pixels_seen >= 700)) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
         rsp_chan.ready <= 1'b0;
      end else begin
         tick++;
         if (mode_left <= 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
               rsp_chan.ready <= (tick % 5 != 0);
            end
         endcase
      end
   end

   // monitor: check each pixel beat, then predict from each command beat
   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected pixel x=%0d y=%0d colour=%h last=%b",
                           rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.pixel_color,
                           rsp_chan.last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.pixel_x !== want.x || rsp_chan.pixel_y !== want.y ||
                   rsp_chan.pixel_color !== want.colour || rsp_chan.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"pixel mismatch: expected x=%0d y=%0d colour=%h last=%b,",
                               " got x=%0d y=%0d colour=%h last=%b"},
                              want.x, want.y, want.colour, want.last,
                              rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.pixel_color,
                              rsp_chan.last);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            raster_command(req_chan.kind, req_chan.start_x, req_chan.start_y,
                           req_chan.end_x, req_chan.end_y, req_chan.draw_color);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int item_total, pick, major_len, minor_len, sx, sy, ex, ey, dx, dy, t;
      int span, steps, live;
      item_total = 0;
      trace = '{default: '0};

      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_START;
      req_chan.start_x    = '0;
      req_chan.start_y    = '0;
      req_chan.end_x      = '0;
      req_chan.end_y      = '0;
      req_chan.draw_color = '0;
      rsp_chan.ready      = 1'b0;

      // directed: step with no line, single point, abandoned full-range diagonal
      push_steps(1);
      push_start(5, 5, 5, 5, 32'h1234_5678);
      push_steps(1);
      push_start(0, 0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
      push_steps(3);
      // reversed endpoints at the top corner, then a step after the line ended
      push_start(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 32'h0000_0000);
      push_steps(3);
      // steep with the minor axis stepping downward
      push_start(100, 200, 102, 195, 32'hA5A5_5A5A);
      push_steps(5);
      // flat line along the top edge, right to left
      push_start(3, COORD_MAX, 0, COORD_MAX, 32'h5A5A_A5A5);
      push_steps(3);
      // error exactly equal to the span does not step the minor axis
      push_start(0, 0, 2, 1, 32'h0F0F_F0F0);
      push_steps(2);
      push_hold();
      item_total = 24;

      // random: mostly whole lines, some abandoned or overrun, some noise
      while (item_total < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            major_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                       : $urandom_range(0, 24);
            minor_len = $urandom_range(0, major_len);
            dx = major_len;
            dy = minor_len;
            if ($urandom_range(0, 1)) begin
               t = dx; dx = dy; dy = t;
            end
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            ex = sx + dx;
            ey = sy + dy;
            if (ex < 0 || ex > COORD_MAX) ex = sx - dx;
            if (ey < 0 || ey > COORD_MAX) ey = sy - dy;
            span = major_len;
            case ($urandom_range(0, 9)) inside
               0, 1: begin
                  steps = span + $urandom_range(1, 3);
               end
               2: begin
                  steps = $urandom_range(0, span);
               end
               default: begin
                  steps = span;
               end
            endcase
            push_start(sx, sy, ex, ey, $urandom);
            push_steps(steps);
            live = (steps < span) ? steps : span;
            item_total += 1 + live;
         end else if (pick < 87) begin
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            ex = $urandom_range(0, COORD_MAX);
            ey = $urandom_range(0, COORD_MAX);
            span = (abs_gap(ex, sx) > abs_gap(ey, sy)) ? abs_gap(ex, sx) : abs_gap(ey, sy);
            steps = $urandom_range(0, 6);
            push_start(sx, sy, ex, ey, $urandom);
            push_steps(steps);
            live = (steps < span) ? steps : span;
            item_total += 1 + live;
         end else if (pick < 97) begin
            push_steps($urandom_range(1, 4));
         end else begin
            push_hold();
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (backlog.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
